FILE: hw/rtl/sss_pkg.sv
// Shared types and constants for the sample stack with statistics.
package sss_pkg;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_QUERY = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_UPD,
        S_SUMA,
        S_RANKA,
        S_DONE,
        S_OUT
    } fsm_t;

endpackage

FILE: hw/rtl/sample_stack_with_stats.sv
// Top level: bounded sample stack with sum, mean and median statistics.
// After reset the block clears its store, writing zero to every entry, before it takes
// a command. Each command then runs from its input transfer to a valid result
// through an update step, a sum pass over the store, a rank walk for each entry
// where every entry is compared against every other through the single read
// port, with a register of the two middle values, and a step that loads the
// output register. The result waits in that register; the next command is taken
// in the cycle after that result has been transferred, so the block takes no new
// command before the last result has gone.
module sample_stack_with_stats
    import sss_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // cmd[1:0], sample_in[17:2], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // status, popped, fill_count, total, mean, median, pad
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0] DEP = (AW + 1)'(DEPTH);
    localparam int LO = (DEPTH % 2 == 0) ? DEPTH / 2 - 1 : (DEPTH - 1) / 2;
    localparam int HI = DEPTH / 2;
    localparam int SW = 16 + AW;
    localparam int RS = SW + AW;
    localparam longint RM = ((longint'(1) << RS) + longint'(DEPTH) - 1) / longint'(DEPTH);
    localparam logic [RS-1:0] RM_V = RS'(RM);

    logic signed [15:0] mem [DEPTH];
    logic signed [15:0] rd_q;
    logic [AW-1:0] raddr, waddr;
    logic          we;
    logic signed [15:0] wdata;

    fsm_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW:0]   i_reg, i_next, j_reg, j_next;
    logic [1:0]    cmd_reg, cmd_next;
    logic signed [15:0] smp_reg, smp_next, cand_reg, cand_next;
    logic signed [15:0] lo_reg, lo_next, hi_reg, hi_next, pop_reg, pop_next;
    logic [AW:0]   less_reg, less_next, leq_reg, leq_next;
    logic signed [SW-1:0] sum_reg, sum_next;
    logic [SW-1:0] quo_reg, quo_next;
    status_t       st_reg, st_next;
    logic          ov_reg, ov_next;
    logic [79:0]   out_reg, out_next;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_q <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg   <= '0;
            i_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            i_reg     <= i_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg <= j_next;      cmd_reg <= cmd_next;   smp_reg <= smp_next;
        cand_reg <= cand_next; lo_reg <= lo_next;    hi_reg <= hi_next;
        pop_reg <= pop_next;  less_reg <= less_next; leq_reg <= leq_next;
        sum_reg <= sum_next;  st_reg <= st_next;     out_reg <= out_next;
        quo_reg <= quo_next;
    end

    logic signed [16:0] mid;
    logic [SW-1:0]      mag;
    logic [SW+RS-1:0]   prod;
    logic signed [SW-1:0] mean_w;
    always_comb
    begin
        mid    = (HI == LO) ? 17'(lo_reg) : (17'(lo_reg) + 17'(hi_reg)) / 17'sd2;
        // divide the magnitude by DEPTH through a reciprocal multiply, then restore the sign;
        // the sum is stable long before the result is loaded
        mag    = sum_reg[SW-1] ? $unsigned(-sum_reg) : $unsigned(sum_reg);
        prod   = (SW + RS)'(mag) * (SW + RS)'(RM_V);
        quo_next = prod[SW+RS-1:RS];
        mean_w = sum_reg[SW-1] ? -$signed(quo_reg) : $signed(quo_reg);
    end

    always_comb
    begin
        state_next = state_reg; cnt_next = cnt_reg; i_next = i_reg; j_next = j_reg;
        cmd_next = cmd_reg; smp_next = smp_reg; cand_next = cand_reg;
        lo_next = lo_reg; hi_next = hi_reg; pop_next = pop_reg;
        less_next = less_reg; leq_next = leq_reg; sum_next = sum_reg;
        st_next = st_reg; ov_next = ov_reg; out_next = out_reg;
        raddr = i_reg[AW-1:0]; waddr = i_reg[AW-1:0]; we = 1'b0; wdata = '0;
        s_tready = (state_reg == S_IDLE);
        unique case (state_reg)
            S_INIT:
            begin
                we = 1'b1;
                i_next = i_reg + 1'b1;
                if (i_reg == DEP - 1'b1)
                begin
                    i_next = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next = s_tdata[1:0];
                    smp_next = s_tdata[17:2];
                    // pop reads the top entry
                    raddr = AW'(cnt_reg - 1'b1);
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                st_next = ST_OK;
                pop_next = '0;
                case (cmd_t'(cmd_reg))
                    CMD_PUSH:
                    begin
                        we = 1'b1;
                        wdata = smp_reg;
                        if (cnt_reg == CW'(DEPTH))
                        begin
                            waddr = AW'(DEPTH - 1);
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            waddr = AW'(cnt_reg);
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    CMD_POP:
                    begin
                        if (cnt_reg == '0)
                            st_next = ST_EMPTY;
                        else
                        begin
                            cnt_next = cnt_reg - 1'b1;
                            pop_next = rd_q;
                        end
                    end
                    CMD_CLEAR: cnt_next = '0;
                    default: ;
                endcase
                i_next = '0;
                sum_next = '0;
                state_next = S_SUMA;
            end
            S_SUMA:
            begin
                // i_reg addresses this cycle; data of i-1 arrives now
                raddr = i_reg[AW-1:0];
                if (i_reg != '0 && (i_reg - 1'b1) < (AW + 1)'(cnt_reg))
                    sum_next = sum_reg + SW'(rd_q);
                i_next = i_reg + 1'b1;
                if (i_reg == DEP)
                begin
                    i_next = '0;
                    j_next = '0;
                    less_next = '0;
                    leq_next = '0;
                    state_next = S_RANKA;
                end
            end
            S_RANKA:
            begin
                // j == 0 fetches candidate i; j>0 fetches entry j-1 to compare
                raddr = (j_reg == '0) ? i_reg[AW-1:0] : AW'(j_reg - 1'b1);
                if (j_reg == 1'b1)
                    cand_next = rd_q;
                else if (j_reg > 1'b1)
                begin
                    if (rd_q < cand_reg)  less_next = less_reg + 1'b1;
                    if (rd_q <= cand_reg) leq_next = leq_reg + 1'b1;
                end
                j_next = j_reg + 1'b1;
                if (j_reg == DEP + 1'b1)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                // rank interval [less, leq) holds sorted positions of the candidate
                if (less_reg <= (AW + 1)'(LO) && (AW + 1)'(LO) < leq_reg)
                    lo_next = cand_reg;
                if (less_reg <= (AW + 1)'(HI) && (AW + 1)'(HI) < leq_reg)
                    hi_next = cand_reg;
                j_next = '0;
                less_next = '0;
                leq_next = '0;
                i_next = i_reg + 1'b1;
                state_next = S_RANKA;
                if (i_reg == DEP - 1'b1)
                begin
                    i_next = '0;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!ov_reg)
                begin
                    out_next = {5'b0, 16'(mid), 16'(mean_w), 20'(sum_reg), 5'(cnt_reg),
                                pop_reg, st_reg};
                    ov_next = 1'b1;
                end
                else if (m_tready)
                begin
                    ov_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = out_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid) else $error("input taken while result pending");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH)) else $error("fill count beyond depth");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("result changed");

endmodule
